>>> rtl/cdeq_pkg.sv
`timescale 1ns / 1ps

package cdeq_pkg;

    localparam int DATA_W = 32;

    // operation codes of an input transaction
    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD      = 3'd0,
        CMD_SHIFT_IN  = 3'd1,
        CMD_APPEND    = 3'd2,
        CMD_SHIFT_OUT = 3'd3,
        CMD_DROP_REAR = 3'd4
    } t_cell_cmd;

endpackage

>>> rtl/circular_double_ended_queue_top.sv
`timescale 1ns / 1ps
// a result is registered and valid in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while each result is taken from the output register
// a result still waiting in the output register holds off the next input transaction
// reset clears the occupancy of every cell, the element count and the output valid
// stored element values are not cleared; no clearing pass is needed after reset

module circular_double_ended_queue_top #(
    parameter int CAPACITY = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_operation,
    input  logic signed [31:0]  i_push_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_popped_value,
    output logic [1:0]          o_status,
    output logic [3:0]          o_entry_count,
    output logic                o_is_full,
    output logic                o_is_empty
);
    import cdeq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // element count, the cells hold the same number of occupied flags
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // chain of cells, front element always in cell 0
    logic [CAPACITY-1:0] w_occ;
    t_data               w_data      [CAPACITY];
    t_data               w_rear_data [CAPACITY];
    t_data               w_rear_value;

    t_cell_cmd w_op_cmd;
    t_cell_cmd w_cmd;
    logic      w_fire;
    logic      w_full;
    logic      w_empty;
    logic [1:0] n_status;
    t_data      n_popped;

    // output register
    logic             r_out_valid;
    t_data            r_popped;
    logic [1:0]       r_status;
    logic [CNT_W-1:0] r_out_count;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CAP_CNT);
    assign w_empty    = (r_count == '0);

    // only the last occupied cell drives its value, the rest give zero
    always_comb begin
        w_rear_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rear_value = w_rear_value | w_rear_data[i];
        end
    end

    // decode the transaction into a chain command and its result
    always_comb begin
        w_op_cmd = CMD_HOLD;
        n_status = ST_DONE;
        n_popped = '0;
        n_count  = r_count;
        case (i_operation)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op_cmd = CMD_SHIFT_IN;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_REAR: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op_cmd = CMD_APPEND;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_op_cmd = CMD_SHIFT_OUT;
                    n_popped = w_data[0];
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_POP_REAR: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_op_cmd = CMD_DROP_REAR;
                    n_popped = w_rear_value;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // cells only move on an accepted transaction
    assign w_cmd = w_fire ? w_op_cmd : CMD_HOLD;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_data w_left_data;
            logic  w_left_occ;
            t_data w_right_data;
            logic  w_right_occ;

            if (g == 0) begin : g_head
                // the front end sees the new value as an always-occupied neighbor
                assign w_left_data = i_push_value;
                assign w_left_occ  = 1'b1;
            end else begin : g_body_left
                assign w_left_data = w_data[g-1];
                assign w_left_occ  = w_occ[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right_data = '0;
                assign w_right_occ  = 1'b0;
            end else begin : g_body_right
                assign w_right_data = w_data[g+1];
                assign w_right_occ  = w_occ[g+1];
            end

            cdeq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_push_value (i_push_value),
                .i_left_data  (w_left_data),
                .i_left_occ   (w_left_occ),
                .i_right_data (w_right_data),
                .i_right_occ  (w_right_occ),
                .o_data       (w_data[g]),
                .o_occ        (w_occ[g]),
                .o_rear_data  (w_rear_data[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_popped    <= n_popped;
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_entry_count  = 4'(r_out_count);
    assign o_is_full      = (r_out_count == CAP_CNT);
    assign o_is_empty     = (r_out_count == '0);

    // occupied cells always match the element count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_occ) == 32'(r_count))
        else $error("cell occupancy disagrees with element count");

    // occupied cells form one run starting at the front cell
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_occ & CAPACITY'(w_occ + CAPACITY'(1))) == '0)
        else $error("occupied cells are not contiguous from the front");

    // the count never exceeds the capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("element count above capacity");

    // a refused transaction leaves the count untouched
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (n_status != ST_DONE)) |=> (r_count == $past(r_count)))
        else $error("refused transaction changed the count");

    // refused transactions report no popped value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DONE)) |-> (o_popped_value == '0))
        else $error("refused transaction carries a popped value");

endmodule

>>> rtl/cdeq_cell.sv
`timescale 1ns / 1ps

module cdeq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cdeq_pkg::t_cell_cmd   i_cmd,
    input  cdeq_pkg::t_data       i_push_value,
    input  cdeq_pkg::t_data       i_left_data,
    input  logic                  i_left_occ,
    input  cdeq_pkg::t_data       i_right_data,
    input  logic                  i_right_occ,
    output cdeq_pkg::t_data       o_data,
    output logic                  o_occ,
    output cdeq_pkg::t_data       o_rear_data
);
    import cdeq_pkg::*;

    t_data r_data;
    t_data n_data;
    logic  r_occ;
    logic  n_occ;
    logic  w_is_last;

    assign w_is_last = r_occ && !i_right_occ;

    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        case (i_cmd)
            CMD_SHIFT_IN: begin
                n_data = i_left_data;
                n_occ  = i_left_occ;
            end
            CMD_APPEND: begin
                // first free cell takes the new element
                if (!r_occ && i_left_occ) begin
                    n_data = i_push_value;
                    n_occ  = 1'b1;
                end
            end
            CMD_SHIFT_OUT: begin
                n_data = i_right_data;
                n_occ  = i_right_occ;
            end
            CMD_DROP_REAR: begin
                if (w_is_last) begin
                    n_occ = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_data      = r_data;
    assign o_occ       = r_occ;
    assign o_rear_data = w_is_last ? r_data : '0;

endmodule

>>> verif/circular_double_ended_queue_top_tb.sv
`timescale 1ns / 1ps

module circular_double_ended_queue_top_tb;
    import cdeq_pkg::*;

    localparam int DEPTH      = 8;
    localparam int RAND_OPS   = 1650;
    localparam int STALL_MAX  = 13;
    localparam int IDLE_LIMIT = 2000;   // cycles with no transaction on either side
    localparam int DRAIN_WAIT = 4;      // result is registered behind its input

    // one result transaction, field by field
    typedef struct packed {
        t_data       popped_value;
        logic [1:0]  status;
        logic [3:0]  entry_count;
        logic        is_full;
        logic        is_empty;
    } t_deq_result;

    // one row of the directed stimulus; typed rows carry their result by hand
    typedef struct {
        logic [1:0]  op;
        t_data       value;
        bit          typed;
        t_deq_result res;
    } t_deq_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_operation;
    t_data       i_push_value;
    logic        o_out_valid;
    logic        i_out_ready;
    t_data       o_popped_value;
    logic [1:0]  o_status;
    logic [3:0]  o_entry_count;
    logic        o_is_full;
    logic        o_is_empty;

    // mirror of the queue contents, kept in step with accepted transactions
    t_data       mirror_store [DEPTH];
    int          head_ptr;
    int          tail_ptr;
    int          held_count;

    t_deq_result pending_results [$];
    t_deq_row    directed_rows [$];
    int          mismatch_count;
    int          idle_cycles;
    int          send_run;
    int          take_run;

    circular_double_ended_queue_top #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_is_full      (o_is_full),
        .o_is_empty     (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // applies one operation to the mirror and returns the result it must produce
    function automatic t_deq_result apply_deq_op(logic [1:0] op, t_data value);
        t_deq_result r;
        r.popped_value = '0;
        r.status       = ST_DONE;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (held_count == DEPTH) begin
                    r.status = ST_FULL;             // refused, nothing moves
                end else if (op == OP_PUSH_FRONT) begin
                    head_ptr = (head_ptr == 0) ? DEPTH - 1 : head_ptr - 1;
                    mirror_store[head_ptr] = value;
                    held_count++;
                end else begin
                    mirror_store[tail_ptr] = value;
                    tail_ptr = (tail_ptr == DEPTH - 1) ? 0 : tail_ptr + 1;
                    held_count++;
                end
            end
            default: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;            // refused, nothing moves
                end else if (op == OP_POP_FRONT) begin
                    r.popped_value = mirror_store[head_ptr];
                    head_ptr = (head_ptr == DEPTH - 1) ? 0 : head_ptr + 1;
                    held_count--;
                end else begin
                    tail_ptr = (tail_ptr == 0) ? DEPTH - 1 : tail_ptr - 1;
                    r.popped_value = mirror_store[tail_ptr];
                    held_count--;
                end
            end
        endcase
        r.entry_count = held_count[3:0];
        r.is_full     = (held_count == DEPTH);
        r.is_empty    = (held_count == 0);
        return r;
    endfunction

    // wait before the next transaction: random, with bursts of back-to-back traffic
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            run_left = $urandom_range(10, 40);
        return $urandom_range(0, STALL_MAX);
    endfunction

    function automatic void add_row(logic [1:0] op, t_data value, bit typed,
                                    t_data popped, logic [1:0] status,
                                    logic [3:0] count, logic full, logic empty);
        t_deq_row row;
        row.op                 = op;
        row.value              = value;
        row.typed              = typed;
        row.res.popped_value   = popped;
        row.res.status         = status;
        row.res.entry_count    = count;
        row.res.is_full        = full;
        row.res.is_empty       = empty;
        directed_rows.push_back(row);
    endfunction

    function automatic void report_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // drives one transaction and records its result once it is accepted;
    // valid only drops when a gap follows, so back-to-back items keep it high
    task automatic issue_op(logic [1:0] op, t_data value, bit typed, t_deq_result hand_res);
        int          gap;
        t_deq_result predicted;
        gap = draw_wait(send_run);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_deq_op(op, value);
        pending_results.push_back(typed ? hand_res : predicted);
    endtask

    // result side: random stalls, every accepted result checked against the oldest one due
    initial begin
        t_deq_result exp_res;
        int          stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(take_run);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual value %0d status %0d",
                         $time, o_popped_value, o_status);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                report_field("popped_value", exp_res.popped_value, o_popped_value);
                report_field("status", exp_res.status, o_status);
                report_field("entry_count", exp_res.entry_count, o_entry_count);
                report_field("is_full", exp_res.is_full, o_is_full);
                report_field("is_empty", exp_res.is_empty, o_is_empty);
            end
        end
    end

    // watchdog: a stretch with no transaction on either channel means a hang
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_deq_result no_res;
        logic [1:0]  op;
        t_data       value;
        int          push_pct;
        int          phase_left;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = OP_PUSH_FRONT;
        i_push_value   = '0;
        i_out_ready    = 1'b0;
        idle_cycles    = 0;
        mismatch_count = 0;
        send_run       = 0;
        take_run       = 0;
        head_ptr       = 0;
        tail_ptr       = 0;
        held_count     = 0;
        no_res         = '0;
        foreach (mirror_store[k]) mirror_store[k] = '0;

        // pops on an empty queue, extreme values through both ends, then fill
        // to capacity with both push kinds, refused pushes when full, and drain
        add_row(OP_POP_FRONT,  '0,            1, '0,           ST_EMPTY, 4'd0, 1'b0, 1'b1);
        add_row(OP_POP_REAR,   '0,            1, '0,           ST_EMPTY, 4'd0, 1'b0, 1'b1);
        add_row(OP_PUSH_REAR,  32'h7fffffff,  1, '0,           ST_DONE,  4'd1, 1'b0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'h80000000,  1, '0,           ST_DONE,  4'd2, 1'b0, 1'b0);
        add_row(OP_POP_REAR,   '0,            1, 32'h7fffffff, ST_DONE,  4'd1, 1'b0, 1'b0);
        add_row(OP_POP_FRONT,  '0,            1, 32'h80000000, ST_DONE,  4'd0, 1'b0, 1'b1);
        add_row(OP_PUSH_FRONT, 32'hffffffff,  0, '0, ST_DONE, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_REAR,  32'h00000000,  0, '0, ST_DONE, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'h55555555,  0, '0, ST_DONE, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_REAR,  32'haaaaaaaa,  0, '0, ST_DONE, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'h00000001,  0, '0, ST_DONE, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_REAR,  32'h7fffffff,  0, '0, ST_DONE, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'h80000000,  0, '0, ST_DONE, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_REAR,  32'h12345678,  1, '0,           ST_DONE,  4'd8, 1'b1, 1'b0);
        add_row(OP_PUSH_REAR,  32'h0badcafe,  1, '0,           ST_FULL,  4'd8, 1'b1, 1'b0);
        add_row(OP_PUSH_FRONT, 32'hfeedf00d,  1, '0,           ST_FULL,  4'd8, 1'b1, 1'b0);
        for (int k = 0; k < 8; k++)
            add_row((k % 2 == 0) ? OP_POP_FRONT : OP_POP_REAR, 32'hffffffff,
                    0, '0, ST_DONE, 4'd0, 1'b0, 1'b0);
        add_row(OP_POP_FRONT,  '0,            1, '0,           ST_EMPTY, 4'd0, 1'b0, 1'b1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            issue_op(directed_rows[k].op, directed_rows[k].value,
                     directed_rows[k].typed, directed_rows[k].res);

        // random part: phases lean toward pushes or pops, or stay balanced, so the count keeps
        // sweeping between empty and full, with refused requests at both ends
        push_pct   = 50;
        phase_left = 0;
        for (int n = 0; n < RAND_OPS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
            case ($urandom_range(0, 15))
                0:       value = 32'h7fffffff;
                1:       value = 32'h80000000;
                2:       value = 32'hffffffff;
                3:       value = '0;
                default: value = $urandom;
            endcase
            issue_op(op, value, 1'b0, no_res);
        end

        // still at the edge that took the last transaction
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cdeq_pkg.sv
rtl/cdeq_cell.sv
rtl/circular_double_ended_queue_top.sv
verif/circular_double_ended_queue_top_tb.sv
